### hdl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types, constants and round helpers shared by the SHA-1 digest unit.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int QUEUE_DEPTH  = 4;
  localparam int DIGEST_WORDS = 5;

  typedef logic [31:0] word_t;
  typedef word_t [DIGEST_WORDS-1:0] digest_t;
  typedef logic [2:0] windex_t;

  // Word 0 (h0) sits at index 0, the right-hand end of the concatenation.
  localparam digest_t INIT_CHAIN = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                    32'hEFCDAB89, 32'h67452301};

  localparam word_t K_CH     = 32'h5A827999;
  localparam word_t K_PARITY = 32'h6ED9EBA1;
  localparam word_t K_MAJ    = 32'h8F1BBCDC;
  localparam word_t K_TAIL   = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [5:0] LENGTH_FILL    = 6'd56;
  localparam logic [5:0] BLOCK_LAST     = 6'd63;
  localparam logic [2:0] LEN_BYTE_LAST  = 3'd7;
  localparam logic [6:0] FOLD_ROUND     = 7'd80;
  localparam windex_t    LAST_INDEX     = 3'd4;
  localparam logic [2:0] DIGEST_COUNT   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } item_t;

  function automatic word_t rol1(word_t x);
    return {x[30:0], x[31]};
  endfunction

  function automatic word_t rol5(word_t x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic word_t rol30(word_t x);
    return {x[1:0], x[31:2]};
  endfunction

  function automatic word_t round_mix(logic [6:0] r, word_t b, word_t c, word_t d);
    word_t f;
    case (r) inside
      [7'd0:7'd19]:  f = (b & c) | (~b & d);
      [7'd40:7'd59]: f = (b & c) | (b & d) | (c & d);
      default:       f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic word_t round_const(logic [6:0] r);
    word_t k;
    case (r) inside
      [7'd0:7'd19]:  k = K_CH;
      [7'd20:7'd39]: k = K_PARITY;
      [7'd40:7'd59]: k = K_MAJ;
      default:       k = K_TAIL;
    endcase
    return k;
  endfunction

endpackage

### hdl/sha1md_front.sv
// ----------------------------------------------------------------------------
// sha1md_front
// Input queue: takes message items, drops idle ones and holds the rest for
// the compression core.
// ----------------------------------------------------------------------------
module sha1md_front #(
  parameter int DEPTH = sha1md_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               has_byte,
  input  logic               is_last,
  output sha1md_pkg::item_t  item,
  output logic               item_valid,
  input  logic               item_take
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  sha1md_pkg::item_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             keep;

  assign full       = (count == DEPTH_CNT);
  // An item with neither a byte nor an end mark changes nothing, so it is
  // accepted and not queued.
  assign keep       = push && !full && (has_byte || is_last);
  assign item_valid = (count != '0);
  assign item       = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (keep) begin
      store[wr_ptr] <= '{data_byte: data_byte, has_byte: has_byte, is_last: is_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (keep) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (item_take) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(keep) - CNT_W'(item_take);
    end
  end

endmodule

### hdl/sha1md_core.sv
// ----------------------------------------------------------------------------
// sha1md_core
// Byte packing, padding sequencer and the 80-round compression loop.
// ----------------------------------------------------------------------------
module sha1md_core (
  input  logic                clk,
  input  logic                rst,
  input  sha1md_pkg::item_t   item,
  input  logic                item_valid,
  output logic                item_take,
  output sha1md_pkg::digest_t digest,
  output logic                load_valid,
  input  logic                load_ready
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_PAD   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t              state;
  logic [511:0]        blk;
  sha1md_pkg::digest_t chain;
  sha1md_pkg::digest_t wv;
  logic [6:0]          rcnt;
  logic [5:0]          fill;
  logic [63:0]         msg_bits;
  logic                padding;
  logic                pad_first;
  logic                len_go;
  logic                pad_done;
  logic [2:0]          len_cnt;

  logic                put_en;
  logic [7:0]          put_val;
  logic [7:0]          pad_val;
  logic [7:0]          len_byte;
  logic                is_len;
  logic                enter_round;
  logic                in_round;
  sha1md_pkg::word_t   w_cur;
  sha1md_pkg::word_t   w_new;
  sha1md_pkg::word_t   t_sum;

  assign item_take  = (state == S_IDLE) && item_valid;
  assign load_valid = (state == S_OUT);
  assign digest     = chain;

  // The length goes out most significant byte first.
  assign len_byte = 8'(msg_bits >> {~len_cnt, 3'b000});
  assign is_len   = !pad_first && (len_go || fill == sha1md_pkg::LENGTH_FILL);

  always_comb begin
    if (pad_first) begin
      pad_val = sha1md_pkg::PAD_BYTE;
    end else if (is_len) begin
      pad_val = len_byte;
    end else begin
      pad_val = 8'h00;
    end
  end

  assign put_en      = (item_take && item.has_byte) || (state == S_PAD);
  assign put_val     = (state == S_PAD) ? pad_val : item.data_byte;
  assign enter_round = put_en && (fill == sha1md_pkg::BLOCK_LAST);
  assign in_round    = (state == S_ROUND) && (rcnt != sha1md_pkg::FOLD_ROUND);

  // The block is a shift line: the current schedule word is always on top, and
  // the word sixteen rounds ahead is appended at the bottom.
  assign w_cur = blk[511:480];
  assign w_new = sha1md_pkg::rol1(blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ w_cur);
  assign t_sum = sha1md_pkg::rol5(wv[0]) + sha1md_pkg::round_mix(rcnt, wv[1], wv[2], wv[3])
               + wv[4] + sha1md_pkg::round_const(rcnt) + w_cur;

  always_ff @(posedge clk) begin
    if (put_en) begin
      blk <= {blk[503:0], put_val};
    end else if (in_round) begin
      blk <= {blk[479:0], w_new};
    end
    if (enter_round) begin
      wv <= chain;
    end else if (in_round) begin
      wv[0] <= t_sum;
      wv[1] <= wv[0];
      wv[2] <= sha1md_pkg::rol30(wv[1]);
      wv[3] <= wv[2];
      wv[4] <= wv[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chain     <= sha1md_pkg::INIT_CHAIN;
      rcnt      <= '0;
      fill      <= '0;
      msg_bits  <= '0;
      padding   <= 1'b0;
      pad_first <= 1'b0;
      len_go    <= 1'b0;
      pad_done  <= 1'b0;
      len_cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_take) begin
            if (item.has_byte) begin
              fill     <= fill + 1'b1;
              msg_bits <= msg_bits + 64'd8;
            end
            if (item.is_last) begin
              padding   <= 1'b1;
              pad_first <= 1'b1;
              len_go    <= 1'b0;
              len_cnt   <= '0;
              pad_done  <= 1'b0;
            end
            // A byte that fills the block is compressed before any padding.
            if (enter_round) begin
              state <= S_ROUND;
            end else if (item.is_last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill      <= fill + 1'b1;
          pad_first <= 1'b0;
          if (is_len) begin
            len_go  <= 1'b1;
            len_cnt <= len_cnt + 1'b1;
            if (len_cnt == sha1md_pkg::LEN_BYTE_LAST) begin
              pad_done <= 1'b1;
            end
          end
          if (enter_round) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (rcnt == sha1md_pkg::FOLD_ROUND) begin
            rcnt <= '0;
            for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
              chain[i] <= chain[i] + wv[i];
            end
            if (pad_done) begin
              state <= S_OUT;
            end else if (padding) begin
              state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            rcnt <= rcnt + 1'b1;
          end
        end
        S_OUT: begin
          if (load_ready) begin
            chain    <= sha1md_pkg::INIT_CHAIN;
            msg_bits <= '0;
            padding  <= 1'b0;
            pad_done <= 1'b0;
            len_go   <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_round_block_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (fill == '0))
    else $error("compression running with bytes already in the next block");

  a_rcnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_ROUND) |-> (rcnt == '0))
    else $error("round counter not cleared outside compression");

  a_fold_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rcnt == sha1md_pkg::FOLD_ROUND) |=> (state != S_ROUND))
    else $error("compression did not end after the fold cycle");

  a_out_after_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (pad_done && len_go && fill == '0))
    else $error("digest offered before the length was appended");

endmodule

### hdl/sha1md_out.sv
// ----------------------------------------------------------------------------
// sha1md_out
// Digest output buffer: holds one finished digest and hands it out word by
// word, h0 first.
// ----------------------------------------------------------------------------
module sha1md_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  input  sha1md_pkg::digest_t digest,
  output logic                load_ready,
  output logic                empty,
  input  logic                pop,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index,
  output logic                last_word
);

  sha1md_pkg::digest_t words;
  logic [2:0]          remain;
  sha1md_pkg::windex_t idx;

  assign empty       = (remain == '0);
  assign load_ready  = empty;
  assign digest_word = words[idx];
  assign word_index  = idx;
  assign last_word   = (idx == sha1md_pkg::LAST_INDEX);

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      words <= digest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      idx    <= '0;
    end else if (load_valid && load_ready) begin
      remain <= sha1md_pkg::DIGEST_COUNT;
      idx    <= '0;
    end else if (pop && !empty) begin
      remain <= remain - 1'b1;
      idx    <= idx + 1'b1;
    end
  end

endmodule

### hdl/sha1_message_digest_unit.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// SHA-1 over a byte stream with a queue-style interface on both sides.
// ----------------------------------------------------------------------------
// Message bytes are pushed one per transfer; an item with is_last set ends the
// message and, five digest words later (h0 first, last_word on h4), the unit
// is ready for the next message. The core takes in message bytes while it is
// idle, and each full 64-byte block then halts intake for the 80 rounds and
// the fold into the chaining value. At message end the padding sequencer
// appends one byte per cycle while no compression runs (9 to 72 bytes) with
// one or two compressions, then hands the digest to the output buffer. The
// input queue of QUEUE_DEPTH items lets bytes of the next message arrive
// while a block is compressed, and the next message's bytes are absorbed
// while the previous digest is still being read out.
module sha1_message_digest_unit #(
  parameter int QUEUE_DEPTH = sha1md_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha1md_pkg::item_t   item;
  logic                item_valid;
  logic                item_take;
  sha1md_pkg::digest_t digest;
  logic                load_valid;
  logic                load_ready;

  sha1md_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .is_last   (is_last),
    .item      (item),
    .item_valid(item_valid),
    .item_take (item_take)
  );

  sha1md_core u_core (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .item_valid(item_valid),
    .item_take (item_take),
    .digest    (digest),
    .load_valid(load_valid),
    .load_ready(load_ready)
  );

  sha1md_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .digest     (digest),
    .load_ready (load_ready),
    .empty      (empty),
    .pop        (pop),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

endmodule
